// ----- sv/selector_number_bitmap_allocator_assert.svh -----
// Assertion macros for the number bitmap allocator.
// Included by the controller and datapath files; depends on nothing else.
`ifndef SELECTOR_NUMBER_BITMAP_ALLOCATOR_ASSERT_SVH
`define SELECTOR_NUMBER_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property at each rising edge, skipped while reset is high
`define SNBA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("snba assertion failed");
// Check a property at each rising edge, reset included
`define SNBA_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("snba assertion failed");
`else
`define SNBA_ASSERT(name, clk, rst, prop)
`define SNBA_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- sv/snba_pkg.sv -----
// Shared constants, codes and control types of the number bitmap allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package snba_pkg;

  // Bitmap geometry
  localparam int NUMBER_COUNT = 8192;
  localparam int WORD_BITS    = 16;
  localparam int WORD_COUNT   = (NUMBER_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W        = $clog2(WORD_BITS);

  // Field widths
  localparam int NUM_IN_W     = 16;
  localparam int CNT_W        = NUM_IN_W + 1;
  localparam int NUM_W        = 13;
  localparam int STATUS_W     = 2;
  localparam int OUT_FIELDS_W = 2 * NUM_W + STATUS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Request kinds
  localparam logic REQ_CLAIM = 1'b0;
  localparam logic REQ_FIND  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_ILLEGAL   = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DATA,
    S_PUSH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic look;
    logic data;
    logic push;
  } snba_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } snba_stat_t;

endpackage

// ----- sv/selector_number_bitmap_allocator.sv -----
// Number bitmap allocator: claims numbers and finds the lowest free one.
// Channels: s_* carries requests, m_* carries one result per request.
// s_tuser is the request kind (claim or find), s_tdata the number to claim.
// m_tdata holds the result number, the status and the highest claimed number.
// After reset the bitmap memory is cleared one word a cycle, all WORD_COUNT words
// (512 at the default size), with s_tready low; then every number is free.
// A request goes through these steps in order: accept, word lookup (free-word
// search tree or claim address into the bitmap memory read port), update of the
// word (read-modify-write for a claim, bit encode for a find), and the load of
// the output register, which raises m_tvalid. One request is in flight at a time.
// The output register holds a result while the receiver stalls, and the next
// request is accepted and worked on meanwhile; it waits in its last step
// until the output register is free.
// Depends on snba_pkg, snba_ctrl and snba_datapath.
module selector_number_bitmap_allocator
  import snba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [NUM_IN_W-1:0]    s_tdata,   // [15:0] number
  input  logic                   s_tuser,   // [0] req_type
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [12:0] result_number, [14:13] status,
                                            // [27:15] highest_claimed, [31:28] zero
);

  snba_cmd_t  cmd;
  snba_stat_t stat;

  // Sequence requests
  snba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Bitmap, search and result path
  snba_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_req_type (s_tuser),
    .in_number   (s_tdata),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_data    (m_tdata)
  );

endmodule

// ----- sv/snba_ctrl.sv -----
// Controller state machine of the number bitmap allocator.
// Depends on snba_pkg and the assertion macro header.
`include "selector_number_bitmap_allocator_assert.svh"

module snba_ctrl
  import snba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  snba_stat_t stat,
  output snba_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clear after reset; per request: accept, look up, update, push result
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_DATA;
      end
      S_DATA: begin
        cmd.data   = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Reset always restarts the clearing pass with input closed
  `SNBA_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (state == S_CLEAR && !s_tready))
  // An accepted transaction always moves on to the lookup
  `SNBA_ASSERT(a_accept_to_look, clk, rst, (s_tvalid && s_tready) |=> state == S_LOOK)

endmodule

// ----- sv/snba_datapath.sv -----
// Datapath of the number bitmap allocator: bitmap memory, word-full vector,
// two-level free-word search, bit encoder, running maximum and output register.
// Depends on snba_pkg and the assertion macro header.
`include "selector_number_bitmap_allocator_assert.svh"

module snba_datapath
  import snba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  snba_cmd_t              cmd,
  output snba_stat_t             stat,
  input  logic                   in_req_type,
  input  logic [NUM_IN_W-1:0]    in_number,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [OUT_TDATA_W-1:0] out_data
);

  // Search tree geometry: groups of words, then a select over the groups
  localparam int GRP_WORDS  = (WORD_COUNT < 16) ? WORD_COUNT : 16;
  localparam int GRP_COUNT  = WORD_COUNT / GRP_WORDS;
  localparam int GRP_IDX_W  = (GRP_WORDS > 1) ? $clog2(GRP_WORDS) : 1;
  localparam int GRP_SEL_W  = (GRP_COUNT > 1) ? $clog2(GRP_COUNT) : 1;
  localparam int GRP_SHIFT  = $clog2(GRP_WORDS);
  localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_FIELDS_W;

  // Bitmap memory and its registered read data
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;

  // Request and working registers
  logic                  req_q;
  logic [NUM_IN_W-1:0]   num_q;
  logic [ADDR_W-1:0]     addr_q;
  logic                  found_q;
  logic [NUM_W-1:0]      res_num_q;
  status_t               res_status_q;
  logic [NUM_W-1:0]      max_q;
  logic [ADDR_W-1:0]     clr_addr;
  logic [WORD_COUNT-1:0] full;

  // Search tree
  logic [GRP_COUNT-1:0] grp_free;
  logic [GRP_IDX_W-1:0] grp_idx [GRP_COUNT];
  logic [GRP_COUNT-1:0] grp_free_q;
  logic [GRP_IDX_W-1:0] grp_idx_q [GRP_COUNT];
  logic [GRP_SEL_W-1:0] grp_sel;
  logic                 any_free;
  logic [ADDR_W-1:0]    find_addr;

  // Claim and find helpers
  logic                 legal;
  logic [ADDR_W-1:0]    claim_addr;
  logic [BIT_W-1:0]     claim_shift;
  logic [WORD_BITS-1:0] claim_mask;
  logic [WORD_BITS-1:0] claim_word;
  logic                 claim_wr;
  logic [BIT_W-1:0]     zpos;

  // Output register
  logic [NUM_W-1:0]    out_num;
  status_t             out_status;
  logic [NUM_W-1:0]    out_max;

  // Decode the claim
  assign legal       = {1'b0, num_q} < CNT_W'(NUMBER_COUNT);
  assign claim_addr  = num_q[BIT_W +: ADDR_W];
  assign claim_shift = BIT_W'(WORD_BITS - 1) - num_q[BIT_W-1:0];
  assign claim_mask  = WORD_BITS'(1) << claim_shift;
  assign claim_word  = rdata | claim_mask;
  assign claim_wr    = cmd.data && (req_q == REQ_CLAIM) && legal;

  // Find the first free word of each group
  always_comb begin
    for (int g = 0; g < GRP_COUNT; g++) begin
      grp_free[g] = ~&full[g*GRP_WORDS +: GRP_WORDS];
      grp_idx[g]  = '0;
      for (int i = GRP_WORDS - 1; i >= 0; i--) begin
        if (!full[g*GRP_WORDS + i]) begin
          grp_idx[g] = GRP_IDX_W'(i);
        end
      end
    end
  end

  // Register the group results every cycle
  always_ff @(posedge clk) begin
    grp_free_q <= grp_free;
    grp_idx_q  <= grp_idx;
  end

  // Pick the first group with a free word
  always_comb begin
    grp_sel  = '0;
    any_free = |grp_free_q;
    for (int g = GRP_COUNT - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        grp_sel = GRP_SEL_W'(g);
      end
    end
  end

  assign find_addr = (ADDR_W'(grp_sel) << GRP_SHIFT) | ADDR_W'(grp_idx_q[grp_sel]);

  // Find the first clear bit from the MSB down
  always_comb begin
    zpos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rdata[WORD_BITS-1-i]) begin
        zpos = BIT_W'(i);
      end
    end
  end

  // Steer the memory ports: clearing pass, else claim write-back
  assign mem_we    = cmd.clear_wr || claim_wr;
  assign mem_waddr = cmd.clear_wr ? clr_addr : addr_q;
  assign mem_wdata = cmd.clear_wr ? '0 : claim_word;
  assign mem_raddr = (req_q == REQ_FIND) ? find_addr : claim_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.look) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Advance the clearing address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign stat.clear_last = (clr_addr == ADDR_W'(WORD_COUNT - 1));
  assign stat.out_free   = !out_valid || out_ready;

  // Track full words and the highest claim
  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= '0;
      max_q <= '0;
    end else if (claim_wr) begin
      full[addr_q] <= &claim_word;
      if (num_q[NUM_W-1:0] > max_q) begin
        max_q <= num_q[NUM_W-1:0];
      end
    end
  end

  // Capture the request, the looked-up word and the result
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_q <= in_req_type;
      num_q <= in_number;
    end
    if (cmd.look) begin
      addr_q  <= mem_raddr;
      found_q <= any_free;
    end
    if (cmd.data) begin
      if (req_q == REQ_CLAIM) begin
        res_num_q    <= legal ? num_q[NUM_W-1:0] : '0;
        res_status_q <= legal ? ST_OK : ST_ILLEGAL;
      end else begin
        res_num_q    <= found_q ? NUM_W'({addr_q, zpos}) : '0;
        res_status_q <= found_q ? ST_OK : ST_EXHAUSTED;
      end
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_num    <= res_num_q;
      out_status <= res_status_q;
      out_max    <= max_q;
    end
  end

  assign out_data = {OUT_PAD_W'(0), out_max, out_status, out_num};

  // The running maximum never falls
  `SNBA_ASSERT(a_max_monotonic, clk, rst, 1'b1 |=> max_q >= $past(max_q))
  // A word picked by the search has a clear bit
  `SNBA_ASSERT(a_found_word_has_room, clk, rst,
    (cmd.data && req_q == REQ_FIND && found_q) |-> !(&rdata))
  // A successful find points into a word that is not full
  `SNBA_ASSERT(a_find_word_free, clk, rst,
    (cmd.push && req_q == REQ_FIND && res_status_q == ST_OK) |-> !full[addr_q])
  // Exhaustion is reported only with every word full
  `SNBA_ASSERT(a_exhausted_all_full, clk, rst,
    (cmd.push && res_status_q == ST_EXHAUSTED) |-> &full)

endmodule

// ----- test/selector_number_bitmap_allocator_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the number bitmap allocator: claim and find requests
// are predicted against a local copy of the bitmap and compared result by result.
// Depends on snba_pkg and the selector_number_bitmap_allocator top level.
module selector_number_bitmap_allocator_test;
  import snba_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int FILL_COUNT = 256;

  typedef struct {
    logic                req;
    logic [NUM_IN_W-1:0] number;
  } request_t;

  typedef struct {
    logic [NUM_W-1:0] result_number;
    status_t          status;
    logic [NUM_W-1:0] highest;
  } grant_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [NUM_IN_W-1:0]    s_tdata = '0;   // [15:0] number
  logic                   s_tuser = 1'b0; // [0] req_type
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [12:0] result_number, [14:13] status,
                                          // [27:15] highest_claimed, [31:28] zero

  request_t request_queue[$];
  grant_t   grant_queue[$];

  // Local copy of the allocator state
  logic [WORD_BITS-1:0] usage_words[WORD_COUNT];
  logic [NUM_W-1:0]     max_claimed;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  int claim_front = 0;
  int fill_order[FILL_COUNT];

  selector_number_bitmap_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one request to the local bitmap and return the grant it produces
  function automatic grant_t grant_for(request_t r);
    grant_t g;
    int     w;
    int     b;
    logic   found;
    g.result_number = '0;
    g.status = ST_OK;
    if (r.req == REQ_CLAIM) begin
      if (int'(r.number) >= NUMBER_COUNT) begin
        g.status = ST_ILLEGAL;
      end else begin
        // MSB of a word stands for its lowest number
        usage_words[r.number / WORD_BITS][WORD_BITS - 1 - (r.number % WORD_BITS)] = 1'b1;
        if (r.number[NUM_W-1:0] > max_claimed) max_claimed = r.number[NUM_W-1:0];
        g.result_number = r.number[NUM_W-1:0];
      end
    end else begin
      found = 1'b0;
      for (w = 0; w < WORD_COUNT && !found; w++) begin
        if (~usage_words[w] != '0) begin
          for (b = WORD_BITS - 1; b >= 0 && !found; b--) begin
            if (!usage_words[w][b]) begin
              found = 1'b1;
              g.result_number = NUM_W'(w * WORD_BITS + (WORD_BITS - 1 - b));
            end
          end
        end
      end
      if (!found) g.status = ST_EXHAUSTED;
    end
    g.highest = max_claimed;
    return g;
  endfunction

  task automatic add_request(logic req, logic [NUM_IN_W-1:0] number);
    request_t r;
    r.req = req;
    r.number = number;
    request_queue.push_back(r);
  endtask

  // Claims close to a moving front (the largest share) so finds land on real holes,
  // plus scattered claims, out-of-range claims and finds with junk numbers
  task automatic add_random_requests(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        add_request(REQ_FIND, NUM_IN_W'($urandom));
      end else if (pick < 65) begin
        add_request(REQ_CLAIM, NUM_IN_W'(claim_front + $urandom_range(0, 3)));
        if ($urandom_range(1) == 1 && claim_front < NUMBER_COUNT - 8) claim_front++;
      end else if (pick < 85) begin
        add_request(REQ_CLAIM, NUM_IN_W'($urandom_range(0, NUMBER_COUNT - 1)));
      end else begin
        add_request(REQ_CLAIM, NUM_IN_W'($urandom));
      end
    end
  endtask

  // Check at the falling edge, once the driver and monitor updates have settled
  task automatic wait_idle();
    while (request_queue.size() != 0 || s_tvalid || grant_queue.size() != 0)
      @(negedge clk);
  endtask

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
               actual);
    end
  endtask

  // Driver: predict on each accepted transaction, then present the next request
  always @(posedge clk) begin
    request_t accepted;
    request_t next_req;
    logic     fire;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        accepted.req = s_tuser;
        accepted.number = s_tdata;
        grant_queue.push_back(grant_for(accepted));
      end
      if (!s_tvalid || fire) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = request_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= next_req.req;
          s_tdata <= next_req.number;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest grant, stall at random
  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (grant_queue.size() == 0) begin
          mismatches++;
          $display("%0t: result with none pending, expected nothing, actual 0x%0h", $time,
                   m_tdata);
        end else begin
          g = grant_queue.pop_front();
          check_field("result_number", g.result_number, m_tdata[NUM_W-1:0]);
          check_field("status", g.status, m_tdata[NUM_W +: STATUS_W]);
          check_field("highest_claimed", g.highest, m_tdata[NUM_W + STATUS_W +: NUM_W]);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("selector_number_bitmap_allocator_test NOT OK");
      $finish;
    end
  end

  initial begin
    int j;
    int t;
    for (int w = 0; w < WORD_COUNT; w++) usage_words[w] = '0;
    max_claimed = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: range edges, repeated claims, finds that do not claim
    add_request(REQ_CLAIM, 16'd0);
    add_request(REQ_CLAIM, NUM_IN_W'(NUMBER_COUNT - 1));
    add_request(REQ_CLAIM, NUM_IN_W'(NUMBER_COUNT));
    add_request(REQ_CLAIM, 16'hFFFF);
    add_request(REQ_CLAIM, 16'h8000);
    add_request(REQ_CLAIM, 16'd0);
    add_request(REQ_FIND, 16'd0);
    add_request(REQ_FIND, 16'hFFFF);
    add_request(REQ_CLAIM, 16'd1);
    add_request(REQ_FIND, 16'h5555);
    add_request(REQ_CLAIM, NUM_IN_W'(WORD_BITS - 1));
    add_request(REQ_CLAIM, NUM_IN_W'(WORD_BITS));
    add_request(REQ_CLAIM, 16'd3);
    add_request(REQ_CLAIM, 16'd2);
    add_request(REQ_FIND, 16'hAAAA);
    add_request(REQ_CLAIM, NUM_IN_W'(NUMBER_COUNT / 2 - 1));
    add_request(REQ_CLAIM, NUM_IN_W'(NUMBER_COUNT - 1));
    add_request(REQ_FIND, 16'd0);
    claim_front = 4;
    add_random_requests(420);
    wait_idle();

    send_idle_pct = 76;
    recv_stall_pct = 0;
    add_random_requests(440);
    wait_idle();

    send_idle_pct = 0;
    recv_stall_pct = 76;
    add_random_requests(440);
    wait_idle();

    // Fill the lowest numbers in shuffled order, so finds must skip a full group of words
    send_idle_pct = 11;
    recv_stall_pct = 11;
    add_random_requests(160);
    for (int i = 0; i < FILL_COUNT; i++) fill_order[i] = i;
    for (int i = FILL_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = t;
    end
    for (int i = 0; i < FILL_COUNT; i++) begin
      add_request(REQ_CLAIM, NUM_IN_W'(fill_order[i]));
      if (i % 32 == 0) add_request(REQ_FIND, NUM_IN_W'($urandom));
    end
    for (int i = 0; i < 6; i++) add_request(REQ_FIND, NUM_IN_W'($urandom));
    add_request(REQ_CLAIM, NUM_IN_W'(NUMBER_COUNT));
    add_request(REQ_CLAIM, 16'd5);
    add_request(REQ_FIND, 16'd0);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && grant_queue.size() == 0) begin
      $display("selector_number_bitmap_allocator_test OK");
    end else begin
      $display("selector_number_bitmap_allocator_test NOT OK");
    end
    $finish;
  end

endmodule
